FILE: sv/mssched_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssched_pkg
// Shared types and constants for the multiplexed servo pulse scheduler.
// ----------------------------------------------------------------------------
package mssched_pkg;

	// channel count and timer width, fixed by the request layout
	localparam int CHANNELS   = 5;
	localparam int TIME_WIDTH = 16;

	// largest timer value, seeds the minimum chain
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

	// off-time register value after reset
	localparam logic [TIME_WIDTH-1:0] OFF_TIME_RESET = TIME_WIDTH'(8760);

	// channel order inside the request and result
	localparam int CH_BASE         = 0;
	localparam int CH_LOWER_ARM    = 1;
	localparam int CH_LOWER_MIRROR = 2;
	localparam int CH_UPPER_ARM    = 3;
	localparam int CH_CLAW         = 4;

	typedef logic [TIME_WIDTH-1:0] time_t;

	// one timer expiry request
	typedef struct packed {
		time_t on_time_base;
		time_t on_time_lower_arm;
		time_t on_time_lower_mirror;
		time_t on_time_upper_arm;
		time_t on_time_claw;
	} in_item_t;

	// one result: pin levels and next delay
	typedef struct packed {
		logic  pin_base;
		logic  pin_lower_arm;
		logic  pin_lower_mirror;
		logic  pin_upper_arm;
		logic  pin_claw;
		time_t next_delay;
	} out_item_t;

	// values a cell hands to its right neighbor
	typedef struct packed {
		time_t least;
	} link_t;

endpackage

FILE: sv/mssched_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssched_cell
// One servo channel: remaining time and phase, with the running minimum
// passed on from the left neighbor to the right neighbor.
// ----------------------------------------------------------------------------
module mssched_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  mssched_pkg::time_t  last_delay,
	input  mssched_pkg::time_t  on_time,
	input  mssched_pkg::time_t  off_time,
	input  mssched_pkg::link_t  link_in,
	output mssched_pkg::link_t  link_out,
	output logic                phase_next
);

	mssched_pkg::time_t remaining_q;
	logic               phase_q;
	mssched_pkg::time_t rem_sub;
	mssched_pkg::time_t rem_next;

	// saturating subtract of the last delay, reload on expiry
	always_comb begin
		rem_sub    = (remaining_q > last_delay) ? (remaining_q - last_delay) : '0;
		rem_next   = rem_sub;
		phase_next = phase_q;
		if (rem_sub == '0) begin
			phase_next = ~phase_q;
			rem_next   = phase_q ? off_time : on_time;
		end
	end

	// running minimum toward the right neighbor
	assign link_out.least = (rem_next < link_in.least) ? rem_next : link_in.least;

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			phase_q     <= 1'b0;
		end else if (tick) begin
			remaining_q <= rem_next;
			phase_q     <= phase_next;
		end
	end

endmodule

FILE: sv/multiplexed_servo_pulse_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_scheduler_top
// Five servo channels on one shared event timer, one cell per channel.
// ----------------------------------------------------------------------------
//  channel | direction | signals                      | transfer
//  in      | into      | in_valid, in_stall, in_data  | in_valid & !in_stall
//  out     | out of    | out_valid, out_stall, out_data | out_valid & !out_stall
//  cfg     | into      | cfg_wr_en, cfg_wr_data       | cfg_wr_en
//
// One request per cycle while in_stall is low; its result appears in the
// output register in the cycle after acceptance. The whole update, subtract,
// reload and the minimum chain across the cells, settles combinationally,
// which sets the clock period. Reset clears every channel to low with zero
// remaining time, so the first request raises all pins. in_stall is high
// only while a result waits in the output register and out_stall holds it.
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_scheduler_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  mssched_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output mssched_pkg::out_item_t out_data,
	input  logic                   cfg_wr_en,
	input  mssched_pkg::time_t     cfg_wr_data
);

	mssched_pkg::time_t    off_time_q;
	mssched_pkg::time_t    last_delay_q;
	logic                  out_valid_q;
	mssched_pkg::out_item_t out_data_q;
	logic                  tick;

	mssched_pkg::time_t on_time [mssched_pkg::CHANNELS];
	mssched_pkg::link_t link    [mssched_pkg::CHANNELS+1];
	logic [mssched_pkg::CHANNELS-1:0] phase_next;

	// request transfer, output register empty or draining
	assign in_stall = out_valid_q & out_stall;
	assign tick     = in_valid & ~in_stall;

	// spread request fields over the cells
	assign on_time[mssched_pkg::CH_BASE]         = in_data.on_time_base;
	assign on_time[mssched_pkg::CH_LOWER_ARM]    = in_data.on_time_lower_arm;
	assign on_time[mssched_pkg::CH_LOWER_MIRROR] = in_data.on_time_lower_mirror;
	assign on_time[mssched_pkg::CH_UPPER_ARM]    = in_data.on_time_upper_arm;
	assign on_time[mssched_pkg::CH_CLAW]         = in_data.on_time_claw;

	// row of channel cells with the minimum chain
	assign link[0].least = mssched_pkg::TIME_MAX;

	for (genvar c = 0; c < mssched_pkg::CHANNELS; c++) begin : g_cell
		mssched_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tick       (tick),
			.last_delay (last_delay_q),
			.on_time    (on_time[c]),
			.off_time   (off_time_q),
			.link_in    (link[c]),
			.link_out   (link[c+1]),
			.phase_next (phase_next[c])
		);
	end

	// off-time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_time_q <= mssched_pkg::OFF_TIME_RESET;
		end else if (cfg_wr_en) begin
			off_time_q <= cfg_wr_data;
		end
	end

	// delay carried to the next expiry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_delay_q <= '0;
		end else if (tick) begin
			last_delay_q <= link[mssched_pkg::CHANNELS].least;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (tick) begin
			out_data_q.pin_base         <= phase_next[mssched_pkg::CH_BASE];
			out_data_q.pin_lower_arm    <= phase_next[mssched_pkg::CH_LOWER_ARM];
			out_data_q.pin_lower_mirror <= phase_next[mssched_pkg::CH_LOWER_MIRROR];
			out_data_q.pin_upper_arm    <= phase_next[mssched_pkg::CH_UPPER_ARM];
			out_data_q.pin_claw         <= phase_next[mssched_pkg::CH_CLAW];
			out_data_q.next_delay       <= link[mssched_pkg::CHANNELS].least;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sv/mssched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssched_checker
// Port-level checks for the servo pulse scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mssched_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  mssched_pkg::out_item_t out_data
);

	// input held off only by a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a blocked result");

	// every accepted request gives a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted request produced no result");

	// a blocked result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

	// a blocked result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("stalled result changed");

endmodule

bind multiplexed_servo_pulse_scheduler_top mssched_checker u_mssched_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
